// ===== rtl/lcdseq_pkg.sv =====
package lcdseq_pkg;

  localparam logic [2:0] INIT_COUNT = 3'd6;
  localparam logic [2:0] INIT_LAST  = 3'd5;

  localparam logic [1:0] OP_CMD   = 2'd0;
  localparam logic [1:0] OP_DATA  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_GOTO  = 2'd3;

  localparam logic [1:0] CFG_ENABLE_PULSE = 2'd0;
  localparam logic [1:0] CFG_NIBBLE_GAP   = 2'd1;
  localparam logic [1:0] CFG_SETTLE       = 2'd2;
  localparam logic [1:0] CFG_POWER_UP     = 2'd3;

  localparam logic [7:0] CMD_CLEAR = 8'h01;
  localparam logic [7:0] CMD_ROW0  = 8'h80;
  localparam logic [7:0] CMD_ROW1  = 8'hC0;

  typedef struct packed {
    logic       tick;
    logic       req_valid;
    logic [1:0] opcode;
    logic [7:0] byte_value;
    logic [5:0] column;
    logic       row;
  } item_t;

  typedef struct packed {
    logic [7:0]  enable_pulse_us;
    logic [15:0] nibble_gap_us;
    logic [15:0] settle_us;
    logic [15:0] power_up_us;
  } cfg_t;

  // power-up command list for 4-bit mode
  function automatic logic [7:0] init_byte(input logic [2:0] step);
    logic [7:0] b;
    case (step)
      3'd0: b = 8'h33;
      3'd1: b = 8'h32;
      3'd2: b = 8'h28;
      3'd3: b = 8'h0C;
      3'd4: b = 8'h06;
      3'd5: b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/lcdseq_in_if.sv =====
interface lcdseq_in_if;
  logic       valid;
  logic       ready;
  logic       tick;
  logic       req_valid;
  logic [1:0] opcode;
  logic [7:0] byte_value;
  logic [5:0] column;
  logic       row;

  modport source (
    output valid, tick, req_valid, opcode, byte_value, column, row,
    input  ready
  );
  modport sink (
    input  valid, tick, req_valid, opcode, byte_value, column, row,
    output ready
  );
endinterface

// ===== rtl/lcdseq_out_if.sv =====
interface lcdseq_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] lcd_nibble;
  logic       lcd_rs;
  logic       lcd_rw;
  logic       lcd_en;
  logic       busy_res;
  logic       init_done;
  logic       request_dropped;

  modport source (
    output valid, lcd_nibble, lcd_rs, lcd_rw, lcd_en, busy_res, init_done,
           request_dropped,
    input  ready
  );
  modport sink (
    input  valid, lcd_nibble, lcd_rs, lcd_rw, lcd_en, busy_res, init_done,
           request_dropped,
    output ready
  );
endinterface

// ===== rtl/lcdseq_cfg_regs.sv =====
module lcdseq_cfg_regs
  import lcdseq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  output cfg_t        cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable_pulse_us <= 8'd1;
      cfg_r.nibble_gap_us   <= 16'd100;
      cfg_r.settle_us       <= 16'd2000;
      cfg_r.power_up_us     <= 16'd20000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENABLE_PULSE: cfg_r.enable_pulse_us <= cfg_wdata[7:0];
        CFG_NIBBLE_GAP:   cfg_r.nibble_gap_us   <= cfg_wdata;
        CFG_SETTLE:       cfg_r.settle_us       <= cfg_wdata;
        CFG_POWER_UP:     cfg_r.power_up_us     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/lcdseq_engine.sv =====
module lcdseq_engine
  import lcdseq_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_vld,
  input  item_t        item,
  input  cfg_t         cfg,
  output logic         in_rdy,
  lcdseq_out_if.source out_ch
);

  typedef enum logic [2:0] {
    PH_POWER, PH_EN_HI, PH_GAP, PH_EN_LO, PH_SETTLE, PH_EXTRA, PH_IDLE
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] delay_count_r, delay_count_nxt;
  logic [7:0]  held_byte_r, held_byte_nxt;
  logic        held_select_r, held_select_nxt;
  logic [2:0]  init_step_r, init_step_nxt;
  logic        extra_settle_r, extra_settle_nxt;

  logic        out_vld_r;
  logic [3:0]  lcd_nibble_r;
  logic        lcd_rs_r;
  logic        lcd_en_r;
  logic        busy_r;
  logic        init_done_r;
  logic        dropped_r;

  logic        step;
  logic        dropped;
  logic [15:0] cnt_inc;
  logic [15:0] len;
  logic [2:0]  step_inc;
  logic [7:0]  goto_byte;

  assign in_rdy = !out_vld_r || out_ch.ready;
  assign step   = in_vld && in_rdy;

  always_comb begin
    case (phase_r)
      PH_POWER: len = cfg.power_up_us;
      PH_EN_HI: len = {8'd0, cfg.enable_pulse_us};
      PH_GAP:   len = cfg.nibble_gap_us;
      PH_EN_LO: len = {8'd0, cfg.enable_pulse_us};
      default:  len = cfg.settle_us;
    endcase
  end

  assign cnt_inc   = delay_count_r + 16'd1;
  assign step_inc  = init_step_r + 3'd1;
  assign goto_byte = (item.row ? CMD_ROW1 : CMD_ROW0) + {2'b00, item.column};

  always_comb begin
    phase_nxt        = phase_r;
    delay_count_nxt  = delay_count_r;
    held_byte_nxt    = held_byte_r;
    held_select_nxt  = held_select_r;
    init_step_nxt    = init_step_r;
    extra_settle_nxt = extra_settle_r;
    dropped          = 1'b0;

    if (phase_r == PH_IDLE) begin
      if (item.req_valid) begin
        phase_nxt        = PH_EN_HI;
        delay_count_nxt  = '0;
        held_select_nxt  = 1'b0;
        extra_settle_nxt = 1'b0;
        case (item.opcode)
          OP_CMD: held_byte_nxt = item.byte_value;
          OP_DATA: begin
            held_byte_nxt   = item.byte_value;
            held_select_nxt = 1'b1;
          end
          OP_CLEAR: begin
            held_byte_nxt    = CMD_CLEAR;
            extra_settle_nxt = 1'b1;
          end
          default: held_byte_nxt = goto_byte;
        endcase
      end
    end else begin
      dropped = item.req_valid;
      if (item.tick) begin
        if (cnt_inc < len) begin
          delay_count_nxt = cnt_inc;
        end else begin
          delay_count_nxt = '0;
          case (phase_r)
            PH_POWER: begin
              init_step_nxt    = '0;
              held_byte_nxt    = init_byte(3'd0);
              held_select_nxt  = 1'b0;
              extra_settle_nxt = 1'b0;
              phase_nxt        = PH_EN_HI;
            end
            PH_EN_HI: phase_nxt = PH_GAP;
            PH_GAP:   phase_nxt = PH_EN_LO;
            PH_EN_LO: phase_nxt = PH_SETTLE;
            default: begin
              if (phase_r == PH_SETTLE && extra_settle_r) begin
                phase_nxt = PH_EXTRA;
              end else if (init_step_r < INIT_COUNT) begin
                init_step_nxt = step_inc;
                if (step_inc < INIT_COUNT) begin
                  // next command of the power-up list
                  held_byte_nxt    = init_byte(step_inc);
                  held_select_nxt  = 1'b0;
                  extra_settle_nxt = (step_inc == INIT_LAST);
                  phase_nxt        = PH_EN_HI;
                end else begin
                  phase_nxt = PH_IDLE;
                end
              end else begin
                phase_nxt = PH_IDLE;
              end
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_POWER;
      delay_count_r  <= '0;
      held_byte_r    <= '0;
      held_select_r  <= 1'b0;
      init_step_r    <= '0;
      extra_settle_r <= 1'b0;
      out_vld_r      <= 1'b0;
    end else begin
      if (step) begin
        phase_r        <= phase_nxt;
        delay_count_r  <= delay_count_nxt;
        held_byte_r    <= held_byte_nxt;
        held_select_r  <= held_select_nxt;
        init_step_r    <= init_step_nxt;
        extra_settle_r <= extra_settle_nxt;
        out_vld_r      <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // result register shows the state left by the request
  always_ff @(posedge clk) begin
    if (step) begin
      lcd_nibble_r <= (phase_nxt == PH_EN_HI || phase_nxt == PH_GAP) ?
                      held_byte_nxt[7:4] : held_byte_nxt[3:0];
      lcd_rs_r     <= held_select_nxt;
      lcd_en_r     <= (phase_nxt == PH_EN_HI || phase_nxt == PH_EN_LO);
      busy_r       <= (phase_nxt != PH_IDLE);
      init_done_r  <= (init_step_nxt >= INIT_COUNT);
      dropped_r    <= dropped;
    end
  end

  assign out_ch.valid           = out_vld_r;
  assign out_ch.lcd_nibble      = lcd_nibble_r;
  assign out_ch.lcd_rs          = lcd_rs_r;
  assign out_ch.lcd_rw          = 1'b0;
  assign out_ch.lcd_en          = lcd_en_r;
  assign out_ch.busy_res        = busy_r;
  assign out_ch.init_done       = init_done_r;
  assign out_ch.request_dropped = dropped_r;

  a_idle_after_init: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> init_step_r == INIT_COUNT)
    else $error("idle reached before init finished");

  a_init_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    init_step_r <= INIT_COUNT)
    else $error("init step out of range");

  a_drop_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    step && item.req_valid && phase_r != PH_IDLE |=> dropped_r && out_vld_r)
    else $error("busy request not flagged");

  a_en_means_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && lcd_en_r |-> busy_r)
    else $error("enable strobe while idle");

  a_power_pins_low: assert property (@(posedge clk) disable iff (!rst_n)
    step && phase_nxt == PH_POWER |=> !lcd_en_r && !lcd_rs_r && lcd_nibble_r == 4'd0)
    else $error("pins driven during power-up wait");

endmodule

// ===== rtl/char_lcd_nibble_write_sequencer.sv =====
// Character LCD write sequencer, 4-bit bus. Each request on in_ch carries a
// microsecond tick flag and an optional command, data, clear or cursor-position
// request; one result per request comes back on out_ch with the LCD pin levels
// and status after that request. Throughput is one request per clock unless out_ch
// holds off: a request is captured in an input register, the phase/delay state
// machine advances in a single step, and the pins land in the result register.
// After reset the sequencer counts power_up_us ticks with all pins low, then
// sends the six init commands; any request that arrives while a transfer or init
// is running is dropped and flagged. The user writes timing registers through
// cfg_* only while the block is idle; the block itself does not enforce this.
module char_lcd_nibble_write_sequencer
  import lcdseq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  lcdseq_in_if.sink   in_ch,
  lcdseq_out_if.source out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  logic  in_vld_r;
  item_t item_r;
  logic  eng_rdy;
  cfg_t  cfg;

  assign in_ch.ready = !in_vld_r || eng_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.tick       <= in_ch.tick;
      item_r.req_valid  <= in_ch.req_valid;
      item_r.opcode     <= in_ch.opcode;
      item_r.byte_value <= in_ch.byte_value;
      item_r.column     <= in_ch.column;
      item_r.row        <= in_ch.row;
    end
  end

  lcdseq_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lcdseq_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (in_vld_r),
    .item   (item_r),
    .cfg    (cfg),
    .in_rdy (eng_rdy),
    .out_ch (out_ch)
  );

endmodule

// ===== sim/char_lcd_nibble_write_sequencer_tb.sv =====
`timescale 1ns / 1ps

module char_lcd_nibble_write_sequencer_tb;
  import lcdseq_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned PHASE_ITEMS = 150;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int DIR_ROWS = 16;

  typedef struct packed {
    logic [3:0] nibble;
    logic       rs;
    logic       rw;
    logic       en;
    logic       busy;
    logic       init_done;
    logic       dropped;
  } pins_t;

  typedef struct packed {
    item_t stim;
    logic  drain;
    logic  use_want;
    pins_t want;
  } dir_row_t;

  typedef enum logic [2:0] {
    SEQ_POWER, SEQ_EN_HI, SEQ_GAP, SEQ_EN_LO, SEQ_SETTLE, SEQ_EXTRA, SEQ_IDLE
  } seq_phase_t;

  localparam logic [7:0] BOOT_CMDS [6] = '{8'h33, 8'h32, 8'h28, 8'h0C, 8'h06, 8'h01};

  // drain: keep ticking afterwards until the sequencer is back to idle
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{'{1'b0, 1'b0, OP_CMD, 8'h00, 6'd0, 1'b0}, 1'b0, 1'b1,
      '{4'h0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0}},
    '{'{1'b0, 1'b1, OP_DATA, 8'hFF, 6'd63, 1'b1}, 1'b0, 1'b1,
      '{4'h0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1}},
    '{'{1'b1, 1'b0, OP_CMD, 8'h00, 6'd0, 1'b0}, 1'b1, 1'b0, '0},
    '{'{1'b1, 1'b1, OP_CMD, 8'h00, 6'd0, 1'b0}, 1'b1, 1'b1,
      '{4'h0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0}},
    '{'{1'b0, 1'b1, OP_DATA, 8'hFF, 6'd0, 1'b0}, 1'b1, 1'b1,
      '{4'hF, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0}},
    '{'{1'b0, 1'b1, OP_DATA, 8'hA5, 6'd21, 1'b0}, 1'b0, 1'b0, '0},
    '{'{1'b1, 1'b1, OP_CMD, 8'h5A, 6'd42, 1'b1}, 1'b1, 1'b0, '0},
    '{'{1'b0, 1'b1, OP_CLEAR, 8'h77, 6'd0, 1'b0}, 1'b1, 1'b1,
      '{4'h0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0}},
    '{'{1'b0, 1'b1, OP_GOTO, 8'h00, 6'd0, 1'b0}, 1'b1, 1'b1,
      '{4'h8, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0}},
    '{'{1'b1, 1'b1, OP_GOTO, 8'h3C, 6'd39, 1'b1}, 1'b1, 1'b0, '0},
    '{'{1'b0, 1'b1, OP_GOTO, 8'h00, 6'd63, 1'b1}, 1'b1, 1'b1,
      '{4'hF, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0}},
    '{'{1'b0, 1'b1, OP_GOTO, 8'hFF, 6'd63, 1'b0}, 1'b1, 1'b0, '0},
    '{'{1'b1, 1'b1, OP_CMD, 8'hFF, 6'd1, 1'b0}, 1'b0, 1'b0, '0},
    '{'{1'b0, 1'b0, OP_DATA, 8'h00, 6'd0, 1'b0}, 1'b0, 1'b0, '0},
    '{'{1'b1, 1'b1, OP_GOTO, 8'h81, 6'd5, 1'b1}, 1'b1, 1'b0, '0},
    '{'{1'b0, 1'b1, OP_DATA, 8'h00, 6'd0, 1'b0}, 1'b1, 1'b0, '0}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  lcdseq_in_if  in_ch ();
  lcdseq_out_if out_ch ();

  char_lcd_nibble_write_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // sequencer prediction state
  cfg_t        timing;
  seq_phase_t  seq_phase;
  logic [15:0] wait_cnt;
  logic [7:0]  cur_byte;
  logic        cur_rs;
  logic [2:0]  boot_idx;
  logic        clear_wait;

  pins_t       pin_queue [$];
  int unsigned errors = 0;
  bit          calm = 1'b0;
  int unsigned holds_asked = 0;
  int unsigned holds_done = 0;
  int unsigned hold_left = 0;

  function automatic void load_next(input logic [7:0] b, input logic rs, input logic extra);
    cur_byte = b;
    cur_rs = rs;
    clear_wait = extra;
    seq_phase = SEQ_EN_HI;
    wait_cnt = '0;
  endfunction

  function automatic void close_byte();
    if (boot_idx < INIT_COUNT) begin
      boot_idx = boot_idx + 3'd1;
      if (boot_idx < INIT_COUNT) begin
        load_next(BOOT_CMDS[boot_idx], 1'b0, boot_idx == INIT_LAST);
        return;
      end
    end
    seq_phase = SEQ_IDLE;
    wait_cnt = '0;
  endfunction

  function automatic pins_t predict_pins(input item_t it);
    pins_t       p;
    logic [15:0] span;
    p = '0;
    if (seq_phase == SEQ_IDLE) begin
      // tick is ignored while idle, a request starts its first pulse right away
      if (it.req_valid) begin
        case (it.opcode)
          OP_CMD:   load_next(it.byte_value, 1'b0, 1'b0);
          OP_DATA:  load_next(it.byte_value, 1'b1, 1'b0);
          OP_CLEAR: load_next(CMD_CLEAR, 1'b0, 1'b1);
          default:  load_next((it.row ? CMD_ROW1 : CMD_ROW0) + {2'b00, it.column}, 1'b0, 1'b0);
        endcase
      end
    end else begin
      p.dropped = it.req_valid;
      if (it.tick) begin
        wait_cnt = wait_cnt + 16'd1;
        case (seq_phase)
          SEQ_POWER:           span = timing.power_up_us;
          SEQ_EN_HI, SEQ_EN_LO: span = {8'h00, timing.enable_pulse_us};
          SEQ_GAP:             span = timing.nibble_gap_us;
          default:             span = timing.settle_us;
        endcase
        // a zero length ends on the first tick, same as one
        if (wait_cnt >= span) begin
          wait_cnt = '0;
          case (seq_phase)
            SEQ_POWER: begin
              boot_idx = '0;
              load_next(BOOT_CMDS[0], 1'b0, 1'b0);
            end
            SEQ_EN_HI: seq_phase = SEQ_GAP;
            SEQ_GAP:   seq_phase = SEQ_EN_LO;
            SEQ_EN_LO: seq_phase = SEQ_SETTLE;
            SEQ_SETTLE: begin
              if (clear_wait) seq_phase = SEQ_EXTRA;
              else close_byte();
            end
            default: close_byte();
          endcase
        end
      end
    end
    p.nibble = (seq_phase == SEQ_EN_HI || seq_phase == SEQ_GAP) ? cur_byte[7:4] : cur_byte[3:0];
    p.rs = cur_rs;
    p.rw = 1'b0;
    p.en = (seq_phase == SEQ_EN_HI || seq_phase == SEQ_EN_LO);
    p.busy = (seq_phase != SEQ_IDLE);
    p.init_done = (boot_idx >= INIT_COUNT);
    return p;
  endfunction

  function automatic item_t tick_item(input int unsigned tick_pct);
    item_t it;
    it.tick = ($urandom_range(0, 99) < tick_pct);
    it.req_valid = 1'b0;
    it.opcode = 2'($urandom_range(0, 3));
    it.byte_value = 8'($urandom);
    it.column = 6'($urandom_range(0, 63));
    it.row = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // requests mostly land while idle so transfers get through; some hit a busy sequencer
  function automatic item_t pick_request();
    item_t it;
    it = tick_item(70);
    if (seq_phase == SEQ_IDLE) it.req_valid = 1'($urandom_range(0, 1));
    else it.req_valid = ($urandom_range(0, 5) == 0);
    return it;
  endfunction

  task automatic offer(input item_t stim, input logic use_want, input pins_t want);
    pins_t p;
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 15) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.tick <= stim.tick;
    in_ch.req_valid <= stim.req_valid;
    in_ch.opcode <= stim.opcode;
    in_ch.byte_value <= stim.byte_value;
    in_ch.column <= stim.column;
    in_ch.row <= stim.row;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    p = predict_pins(stim);
    pin_queue.push_back(use_want ? want : p);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pin_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_timing(input cfg_t c);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_ENABLE_PULSE;
    cfg_wdata <= {8'h00, c.enable_pulse_us};
    @(negedge clk);
    cfg_index <= CFG_NIBBLE_GAP;
    cfg_wdata <= c.nibble_gap_us;
    @(negedge clk);
    cfg_index <= CFG_SETTLE;
    cfg_wdata <= c.settle_us;
    @(negedge clk);
    cfg_index <= CFG_POWER_UP;
    cfg_wdata <= c.power_up_us;
    @(negedge clk);
    cfg_we <= 1'b0;
    timing = c;
  endtask

  task automatic check_field(input string name, input logic [3:0] want, input logic [3:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_done != holds_asked) begin
      holds_done <= holds_asked;
      hold_left <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm || ($urandom_range(0, 99) >= 15);
    end
  end

  always @(posedge clk) begin
    pins_t got;
    pins_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.lcd_nibble, out_ch.lcd_rs, out_ch.lcd_rw, out_ch.lcd_en,
              out_ch.busy_res, out_ch.init_done, out_ch.request_dropped};
      if (pin_queue.size() == 0) begin
        $error("pin result with no request outstanding: %h", got);
        errors++;
      end else begin
        want = pin_queue.pop_front();
        check_field("lcd_nibble", want.nibble, got.nibble);
        check_field("lcd_rs", 4'(want.rs), 4'(got.rs));
        check_field("lcd_rw", 4'(want.rw), 4'(got.rw));
        check_field("lcd_en", 4'(want.en), 4'(got.en));
        check_field("busy_res", 4'(want.busy), 4'(got.busy));
        check_field("init_done", 4'(want.init_done), 4'(got.init_done));
        check_field("request_dropped", 4'(want.dropped), 4'(got.dropped));
      end
    end
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    cfg_t  plan [6];
    item_t burst;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_ENABLE_PULSE;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.tick = 1'b0;
    in_ch.req_valid = 1'b0;
    in_ch.opcode = OP_CMD;
    in_ch.byte_value = '0;
    in_ch.column = '0;
    in_ch.row = 1'b0;
    out_ch.ready = 1'b0;

    timing = '{8'd1, 16'd100, 16'd2000, 16'd20000};
    seq_phase = SEQ_POWER;
    wait_cnt = '0;
    cur_byte = '0;
    cur_rs = 1'b0;
    boot_idx = '0;
    clear_wait = 1'b0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // short power-up and init so the directed part reaches idle quickly
    set_timing('{8'd1, 16'd2, 16'd3, 16'd40});

    for (int k = 0; k < DIR_ROWS; k++) begin
      offer(DIRECTED[k].stim, DIRECTED[k].use_want, DIRECTED[k].want);
      if (DIRECTED[k].drain) begin
        while (seq_phase != SEQ_IDLE) offer(tick_item(75), 1'b0, '0);
      end
    end

    plan[0] = '{8'd1, 16'd1, 16'd1, 16'd1};
    plan[1] = '{8'd0, 16'd0, 16'd0, 16'd0};
    plan[2] = '{8'd2, 16'd3, 16'd5, 16'hFFFF};
    plan[3] = '{8'($urandom_range(1, 4)), 16'($urandom_range(1, 8)),
                16'($urandom_range(1, 12)), 16'($urandom)};
    plan[4] = '{8'd255, 16'd1, 16'd1, 16'd0};
    plan[5] = '{8'($urandom_range(1, 3)), 16'($urandom_range(1, 5)),
                16'($urandom_range(1, 6)), 16'($urandom_range(1, 100))};

    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      set_timing(plan[ph]);
      calm = (ph == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // out side holds off long enough to back up the input
        if (ph == 2 && n == 40) holds_asked++;
        if (ph == 3 && n == 120) wait_drained();
        offer(pick_request(), 1'b0, '0);
      end
    end

    // longest enable pulse: one data write run all the way out
    wait_drained();
    calm = 1'b0;
    set_timing('{8'd255, 16'd4, 16'd4, 16'hFFFF});
    while (seq_phase != SEQ_IDLE) offer(tick_item(100), 1'b0, '0);
    burst = tick_item(100);
    burst.req_valid = 1'b1;
    burst.opcode = OP_DATA;
    offer(burst, 1'b0, '0);
    while (seq_phase != SEQ_IDLE) offer(tick_item(100), 1'b0, '0);

    wait_drained();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
